>>> hdl/fdr_pkg.sv
package fdr_pkg;

  localparam int COS_FRAC_BITS = 14;

  localparam int CW  = 16;                   // cosine input width
  localparam int NW  = 16;                   // refractive index width
  localparam int OW  = 17;                   // reflectance width
  localparam int AW  = COS_FRAC_BITS + 1;    // |cosine| and square roots
  localparam int VW  = 2 * COS_FRAC_BITS + 1;// square root operand
  localparam int RW  = VW + 1;               // square root working value
  localparam int PW  = NW + AW;              // index times cosine or sine
  localparam int DW  = PW + 1;               // ratio denominator
  localparam int MW  = DW + 1;               // ratio partial remainder
  localparam int QW  = 32;                   // Q31 ratio including exact one
  localparam int QSTEPS = 31;
  localparam int SQW = 2 * QW;
  localparam int SUMW = SQW + 1;

  localparam int REG_INDEX_INCIDENT = 0;
  localparam int REG_INDEX_TRANSMIT = 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [NW-1:0] INDEX_RESET = NW'(4096);
  localparam logic [OW-1:0] REFL_ONE    = OW'(65536);

  typedef struct packed {
    logic [VW-1:0] v;
    logic [RW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [PW-1:0]             rem;
    logic [COS_FRAC_BITS-1:0]  q;
  } div_t;

  typedef struct packed {
    logic [DW-1:0] den;
    logic [MW-1:0] rem;
    logic [QW-1:0] q;
    logic          full;
  } rat_t;

  typedef struct packed {
    logic          swap;
    logic          tir;
    logic [AW-1:0] a;
  } side_t;

  // One digit of the bit-pair square root; bitv is the current power of four.
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [RW-1:0] bitv);
    sqrt_t         o;
    logic [RW:0]   t;
    t = {1'b0, s.res} + {1'b0, bitv};
    if ({2'b00, s.v} >= t) begin
      o.v   = VW'({2'b00, s.v} - t);
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.v   = s.v;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One quotient bit of the restoring division by the transmitted index.
  function automatic div_t div_step(input div_t d, input logic [NW-1:0] dvs, input int k);
    div_t          o;
    logic [PW-1:0] sh;
    sh = PW'(dvs) << k;
    o  = d;
    if (d.rem >= sh) begin
      o.rem  = d.rem - sh;
      o.q[k] = 1'b1;
    end
    return o;
  endfunction

  // One bit of the Q31 amplitude ratio.
  function automatic rat_t rat_step(input rat_t r);
    rat_t          o;
    logic [MW-1:0] sh;
    sh = r.rem << 1;
    o  = r;
    o.q = r.q << 1;
    if (sh >= MW'(r.den)) begin
      o.rem  = sh - MW'(r.den);
      o.q[0] = 1'b1;
    end else begin
      o.rem = sh;
    end
    return o;
  endfunction

endpackage

>>> hdl/fdr_if.sv
interface fdr_in_if import fdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] cos_incident;
  modport source (output valid, output cos_incident, input ready);
  modport sink (input valid, input cos_incident, output ready);
endinterface

interface fdr_out_if import fdr_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [OW-1:0] reflectance;
  logic          total_reflection;
  modport source (output valid, output reflectance, output total_reflection, input ready);
  modport sink (input valid, input reflectance, input total_reflection, output ready);
endinterface

interface fdr_cfg_if import fdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NW-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/fresnel_dielectric_reflectance.sv
// Unpolarised dielectric Fresnel reflectance. Each item carries a signed Q2.14 incident
// cosine; the result is the reflectance in Q1.16 (65536 is exactly one) and a flag for
// total internal reflection. The block takes one item in every cycle while the output
// is not stalled. The pipeline is a chain of one-bit-per-stage units: two square roots,
// the division that gives the transmitted sine and the 31-bit amplitude ratios. The
// whole pipeline moves only when the output stage is empty or its item is being taken,
// so a stall holds every stage in place. The two refractive indices are written through
// the configuration channel, which is always ready; they should be written only while
// no item is in flight.
module fresnel_dielectric_reflectance import fdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fdr_cfg_if.sink    cfg,
  fdr_in_if.sink     cos_in,
  fdr_out_if.source  refl_out
);

  localparam int F = COS_FRAC_BITS;

  // Global stage numbers.
  localparam int G_V1  = 1;
  localparam int G_P   = 3 + F;
  localparam int G_PR  = 6 + 3 * F;
  localparam int G_SQ  = 39 + 3 * F;
  localparam int NST   = 41 + 3 * F;

  logic [NW-1:0] index_incident;
  logic [NW-1:0] index_transmit;

  logic          adv;
  logic          vld  [NST];
  side_t         side [NST];

  sqrt_t         s1   [F+2];
  div_t          dv   [F+1];
  sqrt_t         s2   [F+2];
  logic [PW-1:0] xs, ys, xp, yp;
  rat_t          rs   [QSTEPS+1];
  rat_t          rp   [QSTEPS+1];
  logic [SQW-1:0] sqs, sqp;
  logic [OW-1:0] reflectance;
  logic          total_reflection;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_incident <= INDEX_RESET;
      index_transmit <= INDEX_RESET;
    end else if (cfg.valid) begin
      case (int'(cfg.index))
        REG_INDEX_INCIDENT: index_incident <= cfg.data;
        REG_INDEX_TRANSMIT: index_transmit <= cfg.data;
        default: ;
      endcase
    end
  end

  // A single advance enable keeps the whole pipeline in lock step.
  assign adv          = !vld[NST-1] || refl_out.ready;
  assign cos_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NST; g++) vld[g] <= 1'b0;
    end else if (adv) begin
      vld[0] <= cos_in.valid;
      for (int g = 1; g < NST; g++) vld[g] <= vld[g-1];
    end
  end

  // Entry: clamp the cosine, take its magnitude and decide whether the indices swap.
  int    c_in;
  int    c_cl;
  side_t side_in;

  always_comb begin
    c_in = int'(cos_in.cos_incident);
    if (c_in > (1 << F)) begin
      c_cl = 1 << F;
    end else if (c_in < -(1 << F)) begin
      c_cl = -(1 << F);
    end else begin
      c_cl = c_in;
    end
    side_in.swap = c_cl > 0;
    side_in.tir  = 1'b0;
    side_in.a    = AW'((c_cl < 0) ? -c_cl : c_cl);
  end

  // Per-stage pick; unchecked: user keeps indices unchanged while items are in flight.
  function automatic logic [NW-1:0] pick_ni(input side_t s, input logic [NW-1:0] i_inc,
                                            input logic [NW-1:0] i_tr);
    return s.swap ? i_tr : i_inc;
  endfunction

  function automatic logic [NW-1:0] pick_nt(input side_t s, input logic [NW-1:0] i_inc,
                                            input logic [NW-1:0] i_tr);
    return s.swap ? i_inc : i_tr;
  endfunction

  logic [2*AW-1:0] a_sq;
  logic [PW-1:0]   p_prod;
  logic [PW-1:0]   p_lim;
  logic [2*F-1:0]  s2_sq;
  logic [NW-1:0]   ni_p, nt_p, ni_r, nt_r;
  logic [AW-1:0]   c2;

  always_comb begin
    a_sq   = (2*AW)'(side[G_V1-1].a) * (2*AW)'(side[G_V1-1].a);
    ni_p   = pick_ni(side[G_P-1], index_incident, index_transmit);
    nt_p   = pick_nt(side[G_P-1], index_incident, index_transmit);
    p_prod = PW'(ni_p) * PW'(s1[F+1].res[AW-1:0]);
    p_lim  = PW'(nt_p) << F;
    s2_sq  = (2*F)'(dv[F].q) * (2*F)'(dv[F].q);
    ni_r   = pick_ni(side[G_PR-1], index_incident, index_transmit);
    nt_r   = pick_nt(side[G_PR-1], index_incident, index_transmit);
    c2     = s2[F+1].res[AW-1:0];
  end

  logic [DW-1:0] den_s, den_p;
  logic [PW-1:0] dif_s, dif_p;
  logic [QW-1:0] qs, qp;
  logic [SUMW-1:0] sum;

  always_comb begin
    den_s = {1'b0, xs} + {1'b0, ys};
    den_p = {1'b0, xp} + {1'b0, yp};
    dif_s = (xs >= ys) ? xs - ys : ys - xs;
    dif_p = (xp >= yp) ? xp - yp : yp - xp;
    qs    = rs[QSTEPS].full ? (QW'(1) << QSTEPS) : rs[QSTEPS].q;
    qp    = rp[QSTEPS].full ? (QW'(1) << QSTEPS) : rp[QSTEPS].q;
    sum   = SUMW'(sqs) + SUMW'(sqp) + (SUMW'(1) << 46);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int g = 1; g < NST; g++) begin
        if (g != G_P) side[g] <= side[g-1];
      end
      // The total reflection decision replaces the carried flag at its stage.
      side[G_P] <= '{swap: side[G_P-1].swap, tir: (p_prod >= p_lim), a: side[G_P-1].a};

      // First square root: sine of the incident angle.
      s1[0].v   <= VW'(((2*AW)'(1) << (2 * F)) - a_sq);
      s1[0].res <= '0;
      for (int j = 0; j <= F; j++) begin
        s1[j+1] <= sqrt_step(s1[j], RW'(1) << (2 * (F - j)));
      end

      // Snell's law: transmitted sine by restoring division. Each step takes the
      // transmitted index of the item that sits in it.
      dv[0].rem <= p_prod;
      dv[0].q   <= '0;
      for (int j = 0; j < F; j++) begin
        dv[j+1] <= div_step(dv[j], pick_nt(side[G_P+j], index_incident, index_transmit),
                            F - 1 - j);
      end

      // Second square root: cosine of the transmitted angle.
      s2[0].v   <= VW'(((2*F+1)'(1) << (2 * F)) - (2*F+1)'(s2_sq));
      s2[0].res <= '0;
      for (int j = 0; j <= F; j++) begin
        s2[j+1] <= sqrt_step(s2[j], RW'(1) << (2 * (F - j)));
      end

      // Amplitude ratio terms.
      xs <= PW'(nt_r) * PW'(side[G_PR-1].a);
      ys <= PW'(ni_r) * PW'(c2);
      xp <= PW'(ni_r) * PW'(side[G_PR-1].a);
      yp <= PW'(nt_r) * PW'(c2);

      rs[0].den  <= den_s;
      rs[0].rem  <= MW'(dif_s);
      rs[0].q    <= '0;
      rs[0].full <= (den_s == '0) || (DW'(dif_s) >= den_s);
      rp[0].den  <= den_p;
      rp[0].rem  <= MW'(dif_p);
      rp[0].q    <= '0;
      rp[0].full <= (den_p == '0) || (DW'(dif_p) >= den_p);
      for (int j = 0; j < QSTEPS; j++) begin
        rs[j+1] <= rat_step(rs[j]);
        rp[j+1] <= rat_step(rp[j]);
      end

      // Squares, then the rounded mean with saturation.
      sqs <= SQW'(qs) * SQW'(qs);
      sqp <= SQW'(qp) * SQW'(qp);

      if (side[G_SQ].tir) begin
        reflectance      <= REFL_ONE;
        total_reflection <= 1'b1;
      end else begin
        reflectance      <= ((sum >> 47) > SUMW'(REFL_ONE)) ? REFL_ONE : OW'(sum >> 47);
        total_reflection <= 1'b0;
      end
    end
  end

  assign refl_out.valid            = vld[NST-1];
  assign refl_out.reflectance      = reflectance;
  assign refl_out.total_reflection = total_reflection;

endmodule

>>> tb/fdr_tb_pkg.sv
`timescale 1ns / 1ps

package fdr_tb_pkg;
  import fdr_pkg::*;

  typedef struct {
    logic [OW-1:0] reflectance;
    logic          total_reflection;
  } refl_t;

  // Keeps the reflectances still owed by the block, oldest first, and
  // tallies mismatches against them.
  class refl_scoreboard;
    refl_t owed[$];
    int    mismatches;
    int    checked;

    function void note(refl_t r);
      owed.push_back(r);
    endfunction

    function void check(logic [OW-1:0] refl, logic tir);
      refl_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: reflectance %0d tir %0b", refl, tir);
        return;
      end
      e = owed.pop_front();
      checked++;
      if (e.reflectance !== refl || e.total_reflection !== tir) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected reflectance %0d tir %0b, got %0d tir %0b",
                   e.reflectance, e.total_reflection, refl, tir);
      end
    endfunction
  endclass
endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the Fresnel reflectance block. Directed and random cosines are streamed in
// with random gaps on both sides; each accepted item is run through a local
// predictor and the result is compared against the oldest prediction.
module tb;
  import fdr_pkg::*;
  import fdr_tb_pkg::*;

  localparam int LATENCY = 3 * COS_FRAC_BITS + 41;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fdr_cfg_if cfg();
  fdr_in_if  cos_in();
  fdr_out_if refl_out();

  fresnel_dielectric_reflectance uut (
    .clk(clk), .rst(rst), .cfg(cfg), .cos_in(cos_in), .refl_out(refl_out)
  );

  refl_scoreboard sb;
  logic [NW-1:0] n_inc, n_trn;   // the predictor's copy of the two indices
  int items_sent;
  int tir_seen;
  int settings_used;
  bit stimulus_done;

  // Bit-pair integer square root, as the block computes it.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // floor(|x-y|/(x+y) * 2^31); a zero sum or a ratio of one gives exactly 2^31.
  function automatic longint unsigned amp_ratio(longint unsigned x, longint unsigned y);
    longint unsigned den, rem, q;
    den = x + y;
    rem = (x >= y) ? x - y : y - x;
    q = 0;
    if (den == 0 || rem >= den) return 64'd1 << 31;
    for (int i = 0; i < 31; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic refl_t fresnel_predict(logic signed [CW-1:0] cosv);
    longint one, c;
    longint unsigned a, ni, nt, s1, s2, c2, qs, qp, r;
    refl_t o;
    one = longint'(1) << COS_FRAC_BITS;
    c = cosv;
    if (c > one) c = one;
    if (c < -one) c = -one;
    // A positive cosine means the ray leaves from the transmitting side.
    if (c > 0) begin
      ni = n_trn; nt = n_inc; a = c;
    end else begin
      ni = n_inc; nt = n_trn; a = -c;
    end
    s1 = int_sqrt(one * one - a * a);
    if (ni * s1 >= nt * one) begin
      o.reflectance = REFL_ONE;
      o.total_reflection = 1'b1;
      return o;
    end
    s2 = (ni * s1) / nt;
    c2 = int_sqrt(one * one - s2 * s2);
    qs = amp_ratio(nt * a, ni * c2);
    qp = amp_ratio(ni * a, nt * c2);
    r = (qs * qs + qp * qp + (64'd1 << 46)) >> 47;
    if (r > 65536) r = 65536;
    o.reflectance = OW'(r);
    o.total_reflection = 1'b0;
    return o;
  endfunction

  task automatic write_index(int idx, logic [NW-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_IDX_W'(idx);
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_INDEX_INCIDENT) n_inc = value;
    else n_trn = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Sends one cosine after a random gap; valid stays high between
  // back-to-back items.
  task automatic send_cos(logic signed [CW-1:0] cosv);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      cos_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cos_in.valid <= 1'b1;
    cos_in.cos_incident <= cosv;
    do @(posedge clk); while (!cos_in.ready);
    sb.note(fresnel_predict(cosv));
    items_sent++;
    if (fresnel_predict(cosv).total_reflection) tir_seen++;
    @(negedge clk);
  endtask

  // Called at the falling edge right after the last accepted item.
  task automatic drain();
    cos_in.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // Mostly cosines within [-1,1], with some beyond the clamp and some near
  // grazing or normal incidence.
  function automatic logic signed [CW-1:0] rand_cos();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return CW'($urandom);
    if (k == 1) return CW'($urandom_range(0, 64)) - 16'sd32;
    if (k == 2) return $urandom_range(0, 1) ? 16'sd16384 - CW'($urandom_range(0, 64))
                                            : -16'sd16384 + CW'($urandom_range(0, 64));
    return CW'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic run_phase(logic [NW-1:0] ni, logic [NW-1:0] nt, int count);
    write_index(REG_INDEX_INCIDENT, ni);
    write_index(REG_INDEX_TRANSMIT, nt);
    settings_used++;
    for (int i = 0; i < count; i++) send_cos(rand_cos());
    drain();
  endtask

  // The receiver stalls for a random number of cycles before each result.
  initial begin
    int stall;
    refl_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        refl_out.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      refl_out.ready <= 1'b1;
      do @(posedge clk); while (!refl_out.valid);
      sb.check(refl_out.reflectance, refl_out.total_reflection);
      @(negedge clk);
    end
  end

  initial begin
    logic signed [CW-1:0] directed[$];
    sb = new();
    n_inc = INDEX_RESET;
    n_trn = INDEX_RESET;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    cos_in.valid = 1'b0;
    cos_in.cos_incident = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Equal indices at reset: reflectance is zero whatever the angle.
    send_cos(16'sd16384);
    send_cos(-16'sd8192);
    drain();

    // Glass against air: both sides of normal incidence, grazing, clamped
    // extremes, and angles beyond the critical angle from the dense side.
    write_index(REG_INDEX_INCIDENT, 16'd4096);
    write_index(REG_INDEX_TRANSMIT, 16'd6144);
    settings_used++;
    directed = '{16'sh7FFF, 16'sh8000, 16'sd16384, -16'sd16384, 16'sd16385,
                 -16'sd16385, 16'sd0, 16'sd1, -16'sd1, 16'sd2000, -16'sd2000,
                 16'sd8192, -16'sd8192, 16'sd12000, -16'sd12000, 16'sh5555,
                 16'shAAAA, 16'sd11585, 16'sd10000};
    foreach (directed[i]) send_cos(directed[i]);
    drain();

    // Extreme indices, then a spread of random ones.
    run_phase(16'd1, 16'hFFFF, 40);
    run_phase(16'hFFFF, 16'd1, 40);
    run_phase(16'hFFFF, 16'hFFFF, 30);
    run_phase(16'd1, 16'd1, 30);
    for (int p = 0; p < 8; p++)
      run_phase(NW'($urandom_range(1, 65535)), NW'($urandom_range(1, 65535)), 60);
    for (int p = 0; p < 4; p++)
      run_phase(NW'($urandom_range(3000, 12000)), NW'($urandom_range(3000, 12000)), 100);

    $display("Covered %0d cosine items over %0d index settings; %0d total reflections.",
             items_sent, settings_used, tir_seen);
    $display("Compared %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding.", sb.owed.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule
